/* rtl/assert_macros.svh */
// concurrent assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define ASSERT_SYNC(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// checked on every clock edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

/* rtl/dcc_pkg.sv */
package dcc_pkg;

    localparam int DAY_COUNT_BITS = 20;
    localparam int S_TDATA_W = ((DAY_COUNT_BITS + 7) / 8) * 8;

    localparam int YEAR_W = 13;
    localparam int MONTH_W = 4;
    localparam int DOM_W = 5;
    localparam int WEEKDAY_W = 3;
    localparam int M_FIELDS_W = YEAR_W + MONTH_W + DOM_W + WEEKDAY_W;
    localparam int M_TDATA_W = ((M_FIELDS_W + 7) / 8) * 8;

    localparam logic [YEAR_W-1:0] BASE_YEAR = 13'd2000;
    localparam logic [31:0] CYCLE_DAYS = 32'd146097;
    localparam logic [8:0] LONG_YEAR_DAYS = 9'd366;
    localparam logic [8:0] SHORT_YEAR_DAYS = 9'd365;
    localparam logic [WEEKDAY_W-1:0] BASE_WEEKDAY = 3'd6;
    localparam logic [WEEKDAY_W-1:0] WEEK_DAYS = 3'd7;
    localparam logic [4:0] FEB_SHORT_DAYS = 5'd28;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    localparam logic [4:0] MONTH_DAYS [16] = '{
        5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
        5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0
    };

    typedef struct packed {
        logic load;
        logic cycle_step;
        logic year_step;
        logic month_step;
        logic publish;
    } dcc_cmd_t;

    typedef struct packed {
        logic cycle_ge;
        logic year_ge;
        logic month_stop;
    } dcc_status_t;

    function automatic logic [WEEKDAY_W-1:0] week_add(
        input logic [WEEKDAY_W-1:0] a,
        input logic [1:0] b
    );
        logic [WEEKDAY_W:0] s;
        s = {1'b0, a} + {2'b00, b};
        if (s >= {1'b0, WEEK_DAYS}) begin
            s = s - {1'b0, WEEK_DAYS};
        end
        return s[WEEKDAY_W-1:0];
    endfunction

    // weekday plus a day offset below 32, folded with 8 = 1 mod 7
    function automatic logic [WEEKDAY_W-1:0] week_fold(
        input logic [WEEKDAY_W-1:0] a,
        input logic [4:0] b
    );
        logic [5:0] x;
        logic [3:0] s1;
        logic [3:0] s2;
        x = {3'b000, a} + {1'b0, b};
        s1 = {1'b0, x[5:3]} + {1'b0, x[2:0]};
        s2 = {3'b000, s1[3]} + {1'b0, s1[2:0]};
        if (s2 >= {1'b0, WEEK_DAYS}) begin
            s2 = s2 - {1'b0, WEEK_DAYS};
        end
        return s2[WEEKDAY_W-1:0];
    endfunction

endpackage

/* rtl/day_count_to_calendar_date.sv */
// channel | dir | tdata fields, low bit first
// s_      | in  | day_count[19:0], zero pad to 24 bits
// m_      | out | year_out[12:0], month_out[16:13], day_of_month_out[21:17],
//         |     | weekday_out[24:22], zero pad to 32 bits
// one item at a time: load, then c = day_count / 146097 steps of 400 years,
// y < 400 single-year steps, m < 12 month steps, one subtraction per cycle, then publish
// aresetn is synchronous and active low, clears the controller and m_tvalid
// a new item is taken while the previous result waits in the output register
// a stalled result holds the controller before its publish step
`include "assert_macros.svh"

module day_count_to_calendar_date (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [dcc_pkg::S_TDATA_W-1:0]  s_tdata,   // day_count
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [dcc_pkg::M_TDATA_W-1:0]  m_tdata    // year_out, month_out,
                                                      // day_of_month_out, weekday_out
);

    dcc_pkg::dcc_cmd_t    cmd;
    dcc_pkg::dcc_status_t status;

    logic [dcc_pkg::YEAR_W-1:0]    year_out;
    logic [dcc_pkg::MONTH_W-1:0]   month_out;
    logic [dcc_pkg::DOM_W-1:0]     day_of_month_out;
    logic [dcc_pkg::WEEKDAY_W-1:0] weekday_out;

    dcc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    dcc_datapath u_datapath (
        .aclk             (aclk),
        .day_count        (s_tdata[dcc_pkg::DAY_COUNT_BITS-1:0]),
        .cmd              (cmd),
        .status           (status),
        .year_out         (year_out),
        .month_out        (month_out),
        .day_of_month_out (day_of_month_out),
        .weekday_out      (weekday_out)
    );

    assign m_tdata = dcc_pkg::M_TDATA_W'({weekday_out, day_of_month_out, month_out, year_out});

    `ASSERT_SYNC(a_publish_free, cmd.publish |-> (!m_tvalid || m_tready), "result overwritten")
    `ASSERT_SYNC(a_month_range, m_tvalid |-> (month_out >= 4'd1 && month_out <= 4'd12), "bad month")
    `ASSERT_SYNC(a_weekday_range, m_tvalid |-> (weekday_out < 3'd7), "bad weekday")
    `ASSERT_ALWAYS(a_reset_idle, !$past(aresetn) |-> (!m_tvalid && s_tready), "reset not idle")

endmodule

/* rtl/dcc_ctrl.sv */
module dcc_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  dcc_pkg::dcc_status_t status,
    output dcc_pkg::dcc_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CYCLE,
        ST_YEAR,
        ST_MONTH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;

    always_comb begin
        cmd = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    state_next = ST_CYCLE;
                end
            end
            ST_CYCLE: begin
                if (status.cycle_ge) begin
                    cmd.cycle_step = 1'b1;
                end else begin
                    state_next = ST_YEAR;
                end
            end
            ST_YEAR: begin
                if (status.year_ge) begin
                    cmd.year_step = 1'b1;
                end else begin
                    state_next = ST_MONTH;
                end
            end
            ST_MONTH: begin
                if (!status.month_stop) begin
                    cmd.month_step = 1'b1;
                end else if (out_free) begin
                    cmd.publish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.publish) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

/* rtl/dcc_datapath.sv */
module dcc_datapath (
    input  logic                                  aclk,
    input  logic [dcc_pkg::DAY_COUNT_BITS-1:0]    day_count,
    input  dcc_pkg::dcc_cmd_t                     cmd,
    output dcc_pkg::dcc_status_t                  status,
    output logic [dcc_pkg::YEAR_W-1:0]            year_out,
    output logic [dcc_pkg::MONTH_W-1:0]           month_out,
    output logic [dcc_pkg::DOM_W-1:0]             day_of_month_out,
    output logic [dcc_pkg::WEEKDAY_W-1:0]         weekday_out
);

    localparam int DCB = dcc_pkg::DAY_COUNT_BITS;

    logic [DCB-1:0]                    rest_reg, rest_next;
    logic [dcc_pkg::YEAR_W-1:0]        year_reg, year_next;
    logic [1:0]                        mod4_reg, mod4_next;
    logic [6:0]                        mod100_reg, mod100_next;
    logic [8:0]                        mod400_reg, mod400_next;
    logic [dcc_pkg::MONTH_W-1:0]       month_reg, month_next;
    logic [dcc_pkg::WEEKDAY_W-1:0]     wd_reg, wd_next;
    logic [dcc_pkg::YEAR_W-1:0]        year_out_reg, year_out_next;
    logic [dcc_pkg::MONTH_W-1:0]       month_out_reg, month_out_next;
    logic [dcc_pkg::DOM_W-1:0]         dom_out_reg, dom_out_next;
    logic [dcc_pkg::WEEKDAY_W-1:0]     wd_out_reg, wd_out_next;

    logic [31:0] rest_ext;
    logic        leap;
    logic [8:0]  ylen;
    logic [4:0]  mlen;

    assign rest_ext = 32'(rest_reg);
    assign leap = ((mod4_reg == 2'd0) && (mod100_reg != 7'd0)) || (mod400_reg == 9'd0);
    assign ylen = leap ? dcc_pkg::LONG_YEAR_DAYS : dcc_pkg::SHORT_YEAR_DAYS;
    assign mlen = dcc_pkg::MONTH_DAYS[month_reg]
                + {4'd0, (leap && (month_reg == dcc_pkg::MONTH_FEB))};

    assign status.cycle_ge = (rest_ext >= dcc_pkg::CYCLE_DAYS);
    assign status.year_ge = (rest_ext >= 32'(ylen));
    assign status.month_stop = (month_reg == dcc_pkg::MONTH_DEC) || (rest_ext < 32'(mlen));

    always_comb begin
        rest_next = rest_reg;
        year_next = year_reg;
        mod4_next = mod4_reg;
        mod100_next = mod100_reg;
        mod400_next = mod400_reg;
        month_next = month_reg;
        wd_next = wd_reg;
        year_out_next = year_out_reg;
        month_out_next = month_out_reg;
        dom_out_next = dom_out_reg;
        wd_out_next = wd_out_reg;
        if (cmd.load) begin
            rest_next = day_count;
            year_next = dcc_pkg::BASE_YEAR;
            mod4_next = 2'd0;
            mod100_next = 7'd0;
            mod400_next = 9'd0;
            month_next = dcc_pkg::MONTH_JAN;
            wd_next = dcc_pkg::BASE_WEEKDAY;
        end
        // a 400-year cycle is a whole number of weeks
        if (cmd.cycle_step) begin
            rest_next = DCB'(rest_ext - dcc_pkg::CYCLE_DAYS);
            year_next = year_reg + 13'd400;
        end
        if (cmd.year_step) begin
            rest_next = DCB'(rest_ext - 32'(ylen));
            year_next = year_reg + 13'd1;
            mod4_next = mod4_reg + 2'd1;
            mod100_next = (mod100_reg == 7'd99) ? 7'd0 : mod100_reg + 7'd1;
            mod400_next = (mod400_reg == 9'd399) ? 9'd0 : mod400_reg + 9'd1;
            wd_next = dcc_pkg::week_add(wd_reg, leap ? 2'd2 : 2'd1);
        end
        if (cmd.month_step) begin
            rest_next = DCB'(rest_ext - 32'(mlen));
            month_next = month_reg + 4'd1;
            wd_next = dcc_pkg::week_add(wd_reg, 2'(mlen - dcc_pkg::FEB_SHORT_DAYS));
        end
        if (cmd.publish) begin
            year_out_next = year_reg;
            month_out_next = month_reg;
            dom_out_next = rest_ext[4:0] + 5'd1;
            wd_out_next = dcc_pkg::week_fold(wd_reg, rest_ext[4:0]);
        end
    end

    always_ff @(posedge aclk) begin
        rest_reg <= rest_next;
        year_reg <= year_next;
        mod4_reg <= mod4_next;
        mod100_reg <= mod100_next;
        mod400_reg <= mod400_next;
        month_reg <= month_next;
        wd_reg <= wd_next;
        year_out_reg <= year_out_next;
        month_out_reg <= month_out_next;
        dom_out_reg <= dom_out_next;
        wd_out_reg <= wd_out_next;
    end

    assign year_out = year_out_reg;
    assign month_out = month_out_reg;
    assign day_of_month_out = dom_out_reg;
    assign weekday_out = wd_out_reg;

endmodule

/* verif/tb_top.sv */
module tb_top;

    import dcc_pkg::*;

    localparam int PAD_W = S_TDATA_W - DAY_COUNT_BITS;
    localparam int MONTH_LSB = YEAR_W;
    localparam int DOM_LSB = YEAR_W + MONTH_W;
    localparam int WEEKDAY_LSB = YEAR_W + MONTH_W + DOM_W;
    localparam int unsigned MAX_COUNT = (1 << DAY_COUNT_BITS) - 1;

    localparam int unsigned EPOCH_YEAR = 2000;
    localparam int unsigned EPOCH_WEEKDAY = 6;
    localparam int unsigned WEEK_LEN = 7;
    localparam int unsigned ERA_DAYS = 146097;
    localparam int unsigned ERA_YEARS = 400;
    localparam int unsigned LEAP_YEAR_DAYS = 366;
    localparam int unsigned COMMON_YEAR_DAYS = 365;
    localparam int unsigned FIRST_CENTURY_DAYS = 36525;
    localparam int unsigned CENTURY_DAYS = 36524;
    localparam int unsigned FEBRUARY = 2;
    localparam int unsigned DECEMBER = 12;
    localparam int unsigned MONTH_LEN [13] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    localparam int RANDOM_ITEMS = 200;
    localparam int TAIL_CYCLES = 600;
    localparam int DIRECTED_ROWS = 24;

    typedef struct packed {
        logic [YEAR_W-1:0]    year;
        logic [MONTH_W-1:0]   month;
        logic [DOM_W-1:0]     dom;
        logic [WEEKDAY_W-1:0] weekday;
    } calendar_date_t;

    typedef struct packed {
        logic [PAD_W-1:0]          pad_bits;
        logic [DAY_COUNT_BITS-1:0] count;
        logic                      known;
        calendar_date_t            want;
    } directed_row_t;

    // pad bits, day count, date typed in, year, month, day, weekday
    localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{4'h0, 20'd0,       1'b1, '{13'd2000, 4'd1,  5'd1,  3'd6}},
        '{4'h0, 20'd1,       1'b1, '{13'd2000, 4'd1,  5'd2,  3'd0}},
        '{4'h0, 20'd30,      1'b0, '0},
        '{4'h0, 20'd31,      1'b0, '0},
        '{4'h0, 20'd58,      1'b0, '0},
        '{4'h0, 20'd59,      1'b1, '{13'd2000, 4'd2,  5'd29, 3'd2}},
        '{4'h0, 20'd60,      1'b0, '0},
        '{4'h0, 20'd335,     1'b0, '0},
        '{4'h0, 20'd365,     1'b1, '{13'd2000, 4'd12, 5'd31, 3'd0}},
        '{4'h0, 20'd366,     1'b1, '{13'd2001, 4'd1,  5'd1,  3'd1}},
        '{4'h0, 20'd424,     1'b0, '0},
        '{4'h0, 20'd425,     1'b0, '0},
        '{4'h0, 20'd36583,   1'b0, '0},
        '{4'h0, 20'd36584,   1'b0, '0},
        '{4'h0, 20'd146096,  1'b1, '{13'd2399, 4'd12, 5'd31, 3'd5}},
        '{4'h0, 20'd146097,  1'b1, '{13'd2400, 4'd1,  5'd1,  3'd6}},
        '{4'h0, 20'd146156,  1'b0, '0},
        '{4'h0, 20'd1048575, 1'b0, '0},
        '{4'hF, 20'd0,       1'b1, '{13'd2000, 4'd1,  5'd1,  3'd6}},
        '{4'hA, 20'd1048575, 1'b0, '0},
        '{4'h0, 20'd524288,  1'b0, '0},
        '{4'h0, 20'd292194,  1'b0, '0},
        '{4'h0, 20'd1022679, 1'b0, '0},
        '{4'h0, 20'd5,       1'b0, '0}
    };

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // day_count, zero pad
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;   // year_out, month_out, day_of_month_out, weekday_out

    calendar_date_t pending_dates [$];
    int unsigned    items_sent;
    int unsigned    dates_checked;
    int unsigned    mismatches;
    int unsigned    burst_left;
    int unsigned    year_lo;
    int unsigned    year_hi;
    logic [6:0]     weekdays_seen;

    day_count_to_calendar_date DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic bit is_leap(input int unsigned yr);
        return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
    endfunction

    function automatic calendar_date_t count_to_date(input logic [DAY_COUNT_BITS-1:0] count);
        int unsigned rest;
        int unsigned yr;
        int unsigned mo;
        int unsigned span;
        calendar_date_t d;
        rest = 32'(count);
        d.weekday = WEEKDAY_W'((EPOCH_WEEKDAY + rest) % WEEK_LEN);
        yr = EPOCH_YEAR + (rest / ERA_DAYS) * ERA_YEARS;
        rest = rest % ERA_DAYS;
        span = is_leap(yr) ? LEAP_YEAR_DAYS : COMMON_YEAR_DAYS;
        while (rest >= span) begin
            rest = rest - span;
            yr++;
            span = is_leap(yr) ? LEAP_YEAR_DAYS : COMMON_YEAR_DAYS;
        end
        mo = 1;
        while (mo < DECEMBER) begin
            span = MONTH_LEN[mo];
            if (mo == FEBRUARY && is_leap(yr)) begin
                span++;
            end
            if (rest < span) begin
                break;
            end
            rest = rest - span;
            mo++;
        end
        d.year = YEAR_W'(yr);
        d.month = MONTH_W'(mo);
        d.dom = DOM_W'(rest + 1);
        return d;
    endfunction

    task automatic offer_item(input logic [S_TDATA_W-1:0] word, input calendar_date_t want);
        int unsigned gap;
        s_tvalid <= 1'b1;
        s_tdata <= word;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        pending_dates.push_back(want);
        items_sent++;
        burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 15);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    function automatic int unsigned random_count();
        int unsigned sel;
        int unsigned k;
        int base;
        int offset;
        sel = $urandom_range(0, 99);
        if (sel < 40) begin
            return $urandom_range(0, MAX_COUNT);
        end else if (sel < 65) begin
            return $urandom_range(0, 3000);
        end
        if (sel < 85) begin
            // around a 400-year boundary
            base = $urandom_range(1, 7) * ERA_DAYS;
            offset = $urandom_range(0, 800);
            offset = offset - 400;
        end else begin
            // around a century start, leap or not
            k = $urandom_range(1, 28);
            base = (k / 4) * ERA_DAYS;
            if (k % 4 != 0) begin
                base = base + FIRST_CENTURY_DAYS + (k % 4 - 1) * CENTURY_DAYS;
            end
            offset = $urandom_range(0, 120);
            offset = offset - 60;
        end
        base = base + offset;
        if (base < 0) begin
            base = 0;
        end else if (base > MAX_COUNT) begin
            base = MAX_COUNT;
        end
        return base;
    endfunction

    task automatic compare_field(input string what, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            mismatches++;
        end
    endtask

    // receiver: stretches of always ready, stalled, or random ready
    initial begin
        int unsigned run_len;
        int unsigned stall_mode;
        m_tready <= 1'b0;
        forever begin
            run_len = $urandom_range(1, 40);
            stall_mode = $urandom_range(0, 3);
            repeat (run_len) begin
                @(posedge aclk);
                case (stall_mode)
                    0, 1: m_tready <= 1'b1;
                    2: m_tready <= 1'b0;
                    default: m_tready <= 1'($urandom_range(0, 1));
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        calendar_date_t got;
        calendar_date_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.year = m_tdata[YEAR_W-1:0];
            got.month = m_tdata[MONTH_LSB +: MONTH_W];
            got.dom = m_tdata[DOM_LSB +: DOM_W];
            got.weekday = m_tdata[WEEKDAY_LSB +: WEEKDAY_W];
            if (pending_dates.size() == 0) begin
                $display("%0t: unexpected item, expected none, actual %0d-%0d-%0d weekday %0d",
                         $time, got.year, got.month, got.dom, got.weekday);
                mismatches++;
            end else begin
                want = pending_dates.pop_front();
                compare_field("year", 32'(want.year), 32'(got.year));
                compare_field("month", 32'(want.month), 32'(got.month));
                compare_field("day of month", 32'(want.dom), 32'(got.dom));
                compare_field("weekday", 32'(want.weekday), 32'(got.weekday));
                dates_checked++;
                if (got.year < year_lo) begin
                    year_lo = 32'(got.year);
                end
                if (got.year > year_hi) begin
                    year_hi = 32'(got.year);
                end
                if (got.weekday < WEEK_LEN) begin
                    weekdays_seen[got.weekday] = 1'b1;
                end
            end
        end
    end

    initial begin
        #10_000_000;
        $display("timeout with %0d items still expected", pending_dates.size());
        $display("** day_count_to_calendar_date: FAILED **");
        $finish;
    end

    initial begin
        logic [DAY_COUNT_BITS-1:0] count;
        calendar_date_t want;
        items_sent = 0;
        dates_checked = 0;
        mismatches = 0;
        year_lo = '1;
        year_hi = 0;
        weekdays_seen = '0;
        burst_left = $urandom_range(1, 12);
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            want = DIRECTED[i].known ? DIRECTED[i].want : count_to_date(DIRECTED[i].count);
            offer_item({DIRECTED[i].pad_bits, DIRECTED[i].count}, want);
        end

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            count = DAY_COUNT_BITS'(random_count());
            offer_item({{PAD_W{1'b0}}, count}, count_to_date(count));
        end
        s_tvalid <= 1'b0;

        while (pending_dates.size() != 0) begin
            @(posedge aclk);
        end
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("%0d day counts sent, %0d dates checked, %0d mismatches", items_sent,
                 dates_checked, mismatches);
        $display("years %0d to %0d reached, weekdays seen %b", year_lo, year_hi,
                 weekdays_seen);
        if (mismatches == 0 && pending_dates.size() == 0) begin
            $display("** day_count_to_calendar_date: PASSED **");
        end else begin
            $display("** day_count_to_calendar_date: FAILED **");
        end
        $finish;
    end

endmodule
